// ===== src/fmva_pkg.sv =====
// shared types, constants and helpers for the fm voice allocator
package fmva_pkg;

  localparam int unsigned VoiceCount = 18;
  localparam int unsigned StampBits  = 32;
  localparam int unsigned IdxBits    = 5;
  localparam int unsigned PartnerOfs = 3;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_TWO   = 2'd1;
  localparam logic [1:0] MODE_FOUR  = 2'd2;
  localparam logic [1:0] MODE_BOUND = 2'd3;

  localparam logic [2:0] ADDR_ACTIVE = 3'd0;
  localparam logic [2:0] ADDR_FOUROP = 3'd4;

  typedef struct packed {
    logic [1:0]           mode;
    logic [StampBits-1:0] stamp;
    logic [6:0]           key;
    logic [3:0]           owner;
  } voice_t;

  function automatic logic is_head(input logic [IdxBits-1:0] i);
    return (i < IdxBits'(3) || (i > IdxBits'(8) && i < IdxBits'(12)))
           && ({1'b0, i} + (IdxBits+1)'(PartnerOfs) < (IdxBits+1)'(VoiceCount));
  endfunction

  function automatic logic is_tail(input logic [IdxBits-1:0] i);
    return (i > IdxBits'(2) && i < IdxBits'(6)) || (i > IdxBits'(11) && i < IdxBits'(15));
  endfunction

endpackage

// ===== src/fm_voice_allocator_core.sv =====
// fm voice allocator top level: sequencer around a rotating ring of voice cells
// transfer to result valid: note on passes search rotation, pick, write rotation and done;
//   note off passes write rotation and done, a refused four-op goes straight to done
// throughput: one item at a time; next transfer taken the cycle after the result is
//   loaded, later while a result stalls
// reset: all voices off, stamps and the stamp counter zero, active_voices 18, four-op on
module fm_voice_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic        four_op_i,
  input  logic [3:0]  midi_channel_i,
  input  logic [6:0]  note_number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        granted_o,
  output logic [4:0]  voice_index_o,
  output logic [1:0]  cost_tier_o,
  output logic [17:0] released_mask_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned N  = fmva_pkg::VoiceCount;
  localparam int unsigned IB = fmva_pkg::IdxBits;
  localparam int unsigned SB = fmva_pkg::StampBits;
  localparam int unsigned PO = fmva_pkg::PartnerOfs;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;  // note-on search rotation
  localparam logic [2:0] S_PICK  = 3'd2;  // choose best tier, ring parked at voice 0
  localparam logic [2:0] S_APPLY = 3'd3;  // write rotation (note on and note off)
  localparam logic [2:0] S_DONE  = 3'd4;  // load result register

  logic [2:0] st_q, st_d;

  // config registers
  logic [4:0] active_q;
  logic       fouren_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 5'(N);
      fouren_q <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr == fmva_pkg::ADDR_ACTIVE) active_q <= pwdata[4:0];
      if (paddr == fmva_pkg::ADDR_FOUROP) fouren_q <= pwdata[0];
    end
  end
  always_comb begin
    prdata = '0;
    case (paddr)
      fmva_pkg::ADDR_ACTIVE: prdata = {27'd0, active_q};
      fmva_pkg::ADDR_FOUROP: prdata = {31'd0, fouren_q};
      default:               prdata = '0;
    endcase
  end

  // latched item
  logic       act_q, w4_q;
  logic [3:0] ch_q;
  logic [6:0] key_q;
  logic [4:0] nscan_q;

  // ring: cell k holds voice (pos_q + k) mod N; cell 0 is the head, the partner
  // slot (head+3) sits at cell 3; data moves from cell k+1 to cell k
  fmva_pkg::voice_t ring [N];
  fmva_pkg::voice_t head_in;   // head voice after its update, wraps to the last cell
  fmva_pkg::voice_t tail_new;  // partner voice after its update
  logic             tail_wr;
  logic             shift;
  logic [IB-1:0]    pos_q;     // voice index currently at cell 0
  logic [IB-1:0]    cnt_q;     // steps taken in this rotation

  for (genvar k = 0; k < N; k++) begin : g_cell
    fmva_pkg::voice_t nxt;
    if (k == N - 1) begin : g_wrap
      assign nxt = head_in;
    end else if (k == PO - 1) begin : g_tail
      // partner patch lands as the partner moves from cell 3 to cell 2
      assign nxt = tail_wr ? tail_new : ring[k+1];
    end else begin : g_mid
      assign nxt = ring[k+1];
    end
    fmva_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .prev_i (nxt),
      .voice_o(ring[k])
    );
  end

  // search state: best candidate per tier
  logic          bv_q [3];
  logic [SB-1:0] bt_q [3];
  logic [IB-1:0] bi_q [3];
  logic [SB-1:0] ctr_q, ctr_d;
  logic [SB-1:0] stamp_b;
  logic          found_q;
  logic [IB-1:0] win_q;
  logic [1:0]    tier_q;
  logic [17:0]   rel_q;

  // result register
  logic        ov_q;
  logic        og_q;
  logic [4:0]  oi_q;
  logic [1:0]  ot_q;
  logic [17:0] om_q;
  logic        out_free;

  // candidate evaluation of the head voice
  fmva_pkg::voice_t hv, pv;
  logic             in_range, cand;
  logic [1:0]       ctier;
  logic [SB-1:0]    cwhen;
  assign hv = ring[0];
  assign pv = ring[PO];
  assign in_range = pos_q < nscan_q;

  always_comb begin
    cand  = in_range && hv.mode != fmva_pkg::MODE_BOUND;
    ctier = 2'd0;
    cwhen = hv.stamp;
    if (w4_q) begin
      if (!fmva_pkg::is_head(pos_q)) cand = 1'b0;
      if (hv.mode != fmva_pkg::MODE_OFF) ctier = ctier + 2'd1;
      // compared time is the later of head and sounding partner
      if (pv.mode == fmva_pkg::MODE_TWO) begin
        ctier = ctier + 2'd1;
        if (pv.stamp > cwhen) cwhen = pv.stamp;
      end
    end else begin
      if (fmva_pkg::is_head(pos_q) || fmva_pkg::is_tail(pos_q) ||
          hv.mode != fmva_pkg::MODE_OFF) ctier = ctier + 2'd1;
      if (hv.mode != fmva_pkg::MODE_OFF) ctier = ctier + 2'd1;
    end
  end

  // apply phase decisions on the head voice
  logic        hit_off, hit_on, has_p;
  logic [17:0] rel_add;
  assign has_p = {1'b0, pos_q} + (IB+1)'(PO) < (IB+1)'(N);
  assign hit_off = act_q && in_range &&
                   (hv.mode == fmva_pkg::MODE_TWO || hv.mode == fmva_pkg::MODE_FOUR) &&
                   hv.owner == ch_q && hv.key == key_q;
  assign hit_on = !act_q && found_q && pos_q == win_q;
  assign stamp_b = ctr_q + SB'(1);

  // head stamp first, partner stamp second, one counter step each
  always_comb begin
    head_in  = hv;
    tail_new = pv;
    tail_wr  = 1'b0;
    rel_add  = '0;
    ctr_d    = ctr_q;
    if (st_q == S_APPLY) begin
      if (hit_off) begin
        head_in.mode   = fmva_pkg::MODE_OFF;
        head_in.stamp  = ctr_q;
        rel_add[pos_q] = 1'b1;
        ctr_d = ctr_q + SB'(1);
        if (hv.mode == fmva_pkg::MODE_FOUR && has_p) begin
          tail_wr        = 1'b1;
          tail_new.mode  = fmva_pkg::MODE_OFF;
          tail_new.stamp = stamp_b;
          rel_add[pos_q + IB'(PO)] = 1'b1;
          ctr_d = ctr_q + SB'(2);
        end
      end else if (hit_on) begin
        head_in.stamp = ctr_q;
        head_in.key   = key_q;
        head_in.owner = ch_q;
        ctr_d = ctr_q + SB'(1);
        if (w4_q) begin
          head_in.mode = fmva_pkg::MODE_FOUR;
          if (pv.mode == fmva_pkg::MODE_TWO) rel_add[pos_q + IB'(PO)] = 1'b1;
          tail_wr        = 1'b1;
          tail_new.mode  = fmva_pkg::MODE_BOUND;
          tail_new.stamp = stamp_b;
          tail_new.key   = key_q;
          tail_new.owner = ch_q;
          ctr_d = ctr_q + SB'(2);
        end else begin
          head_in.mode = fmva_pkg::MODE_TWO;
          // a two-op note on a four-op voice frees its partner
          if (hv.mode == fmva_pkg::MODE_FOUR && has_p) begin
            tail_wr        = 1'b1;
            tail_new.mode  = fmva_pkg::MODE_OFF;
            tail_new.stamp = stamp_b;
            rel_add[pos_q + IB'(PO)] = 1'b1;
            ctr_d = ctr_q + SB'(2);
          end
        end
      end
    end
  end

  // the ring moves one step every search and write cycle
  assign shift = (st_q == S_SCAN) || (st_q == S_APPLY);

  // result register parts the sides: a new item may start while a result waits
  assign in_stall_o = (st_q != S_IDLE);
  assign out_free   = !ov_q || !out_stall_i;

  logic do_in;
  assign do_in = in_valid_i && !in_stall_o;

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (do_in) begin
          if (action_i) st_d = S_APPLY;
          else if (four_op_i && !fouren_q) st_d = S_DONE;
          else st_d = S_SCAN;
        end
      end
      S_SCAN:  if (cnt_q == IB'(N-1)) st_d = S_PICK;
      S_PICK:  st_d = S_APPLY;
      S_APPLY: if (cnt_q == IB'(N-1)) st_d = S_DONE;
      S_DONE:  if (out_free) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      pos_q   <= '0;
      cnt_q   <= '0;
      ctr_q   <= '0;
      act_q   <= 1'b0;
      w4_q    <= 1'b0;
      ch_q    <= '0;
      key_q   <= '0;
      nscan_q <= '0;
      found_q <= 1'b0;
      win_q   <= '0;
      tier_q  <= '0;
      rel_q   <= '0;
      for (int t = 0; t < 3; t++) begin
        bv_q[t] <= 1'b0;
        bt_q[t] <= '0;
        bi_q[t] <= '0;
      end
    end else begin
      st_q  <= st_d;
      ctr_q <= ctr_d;
      if (shift) begin
        pos_q <= (pos_q == IB'(N-1)) ? '0 : pos_q + IB'(1);
        cnt_q <= (cnt_q == IB'(N-1)) ? '0 : cnt_q + IB'(1);
      end
      if (do_in) begin
        act_q   <= action_i;
        w4_q    <= four_op_i;
        ch_q    <= midi_channel_i;
        key_q   <= note_number_i;
        nscan_q <= (active_q > 5'(N)) ? 5'(N) : active_q;
        cnt_q   <= '0;
        found_q <= 1'b0;
        rel_q   <= '0;
        tier_q  <= '0;
        win_q   <= '0;
        for (int t = 0; t < 3; t++) bv_q[t] <= 1'b0;
      end
      // oldest stamp wins, lowest index on ties
      if (st_q == S_SCAN && cand && (!bv_q[ctier] || cwhen < bt_q[ctier])) begin
        bv_q[ctier] <= 1'b1;
        bt_q[ctier] <= cwhen;
        bi_q[ctier] <= pos_q;
      end
      if (st_q == S_PICK) begin
        found_q <= bv_q[0] || bv_q[1] || bv_q[2];
        if (bv_q[0]) begin
          win_q  <= bi_q[0];
          tier_q <= 2'd0;
        end else if (bv_q[1]) begin
          win_q  <= bi_q[1];
          tier_q <= 2'd1;
        end else begin
          win_q  <= bi_q[2];
          tier_q <= 2'd2;
        end
      end
      if (st_q == S_APPLY) rel_q <= rel_q | rel_add;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      og_q <= 1'b0;
      oi_q <= '0;
      ot_q <= '0;
      om_q <= '0;
    end else if (st_q == S_DONE && out_free) begin
      ov_q <= 1'b1;
      og_q <= found_q && !act_q;
      oi_q <= (found_q && !act_q) ? win_q : '0;
      ot_q <= (found_q && !act_q) ? tier_q : '0;
      om_q <= rel_q;
    end else if (ov_q && !out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  assign out_valid_o     = ov_q;
  assign granted_o       = og_q;
  assign voice_index_o   = oi_q;
  assign cost_tier_o     = ot_q;
  assign released_mask_o = om_q;
endmodule

// ===== src/fmva_cell.sv =====
// one voice slot of the rotating voice ring
module fmva_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  fmva_pkg::voice_t prev_i,
  output fmva_pkg::voice_t voice_o
);
  fmva_pkg::voice_t v_q, v_d;

  // on a shift the cell takes its neighbor's voice, possibly patched by the sequencer
  always_comb begin
    v_d = v_q;
    if (shift_i) v_d = prev_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q.mode  <= fmva_pkg::MODE_OFF;
      v_q.stamp <= '0;
      v_q.key   <= '0;
      v_q.owner <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign voice_o = v_q;
endmodule

// ===== src/fmva_checker.sv =====
// port-level assertions for the fm voice allocator, bound to the top level
module fmva_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        granted_o,
  input logic [4:0]  voice_index_o,
  input logic [1:0]  cost_tier_o,
  input logic [17:0] released_mask_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(released_mask_o))
    else $error("stalled result changed");
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && granted_o |-> voice_index_o < 5'd18 && cost_tier_o != 2'd3)
    else $error("bad voice index or tier");
  a_nogrant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !granted_o |-> voice_index_o == 5'd0 && cost_tier_o == 2'd0)
    else $error("ungranted result carries a voice");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");
endmodule

bind fm_voice_allocator_core fmva_checker u_fmva_checker (.*);
